### src/tcc_pkg.sv
// Shared types and constants for the text console cursor engine.
package tcc_pkg;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP,
        ST_DONE
    } state_t;

    localparam int CELL_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam int TAB_STEP = 4;

    localparam logic [7:0] ATTR_RESET = 8'h0C;

endpackage

### src/tcc_screen_ram.sv
// Screen cell memory: one write port, one read port, registered read data.
module tcc_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [tcc_pkg::CELL_W-1:0] wdata,
    input  logic [AW-1:0]              raddr,
    output logic [tcc_pkg::CELL_W-1:0] rdata
);

    logic [tcc_pkg::CELL_W-1:0] mem [DEPTH];
    logic [tcc_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/text_console_cursor_engine.sv
// Top level: command decode, cursor update, screen sweeps and result register.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------------
//  command  | start, busy                | opcode, char_code, target_row, target_col,
//           |                            | cell_index
//  result   | done (one-cycle strobe)    | cursor_row_out, cursor_col_out,
//           |                            | cursor_position, cell_data, scrolled
//  config   | char_attribute_we          | char_attribute
//
// Put, set cursor and read: a word is taken in idle, runs through the execute and done
// states, done pulses, and the next word can be taken on the edge ending the done cycle.
// Scroll and clear add one pass over the screen memory, one cell per cycle through the
// single write port (scroll copies through the read port). After reset busy stays high
// while the memory is zeroed. Results stay in the output registers until the next done;
// done marks the cycle in which a new result first appears.
module text_console_cursor_engine #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [7:0]  char_code,
    input  logic [4:0]  target_row,
    input  logic [6:0]  target_col,
    input  logic [10:0] cell_index,
    input  logic        char_attribute_we,
    input  logic [7:0]  char_attribute,
    output logic        done,
    output logic [4:0]  cursor_row_out,
    output logic [6:0]  cursor_col_out,
    output logic [10:0] cursor_position,
    output logic [15:0] cell_data,
    output logic        scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int RW1   = RW + 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam int CW1   = $clog2(COLUMNS + tcc_pkg::TAB_STEP);

    tcc_pkg::state_t state_reg, state_next;

    logic [7:0]  attr_reg;
    logic [1:0]  op_reg;
    logic [7:0]  char_reg;
    logic [4:0]  trow_reg;
    logic [6:0]  tcol_reg;
    logic [10:0] idx_reg;

    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic          scroll_reg, scroll_next;

    logic [AW-1:0]              cnt_reg, cnt_next;
    logic [tcc_pkg::CELL_W-1:0] fill_reg, fill_next;
    logic                       pw_valid_reg, pw_valid_next;
    logic [AW-1:0]              pw_addr_reg, pw_addr_next;
    logic                       pw_copy_reg, pw_copy_next;

    logic        done_reg, done_next;
    logic [4:0]  row_out_reg;
    logic [6:0]  col_out_reg;
    logic [10:0] pos_out_reg;
    logic [15:0] cell_out_reg, cell_out_next;
    logic        scrolled_out_reg;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [tcc_pkg::CELL_W-1:0] ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [tcc_pkg::CELL_W-1:0] ram_rdata;

    logic [AW-1:0]  cur_addr;
    logic           printable;
    logic [CW1-1:0] col_x;
    logic [RW1-1:0] row_x;
    logic           put_scroll;
    logic           read_oob;
    logic           accept;

    assign accept   = start && !busy;
    assign busy     = (state_reg != tcc_pkg::ST_IDLE);
    assign cur_addr = AW'(32'(row_reg) * COLUMNS) + AW'(col_reg);
    assign read_oob = (32'(idx_reg) >= CELLS);

    always_comb
    begin
        printable = !(char_reg inside {tcc_pkg::CH_NEWLINE, tcc_pkg::CH_RETURN,
                                       tcc_pkg::CH_TAB, tcc_pkg::CH_BACKSPACE});
    end

    // next cursor for a put
    always_comb
    begin
        col_x = CW1'(col_reg);
        row_x = RW1'(row_reg);
        case (char_reg)
            tcc_pkg::CH_NEWLINE:
            begin
                row_x = RW1'(row_reg) + RW1'(1);
                col_x = '0;
            end
            tcc_pkg::CH_RETURN:
            begin
                col_x = '0;
            end
            tcc_pkg::CH_TAB:
            begin
                col_x = (CW1'(col_reg) + CW1'(tcc_pkg::TAB_STEP))
                        & ~CW1'(tcc_pkg::TAB_STEP - 1);
            end
            tcc_pkg::CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    col_x = CW1'(col_reg) - CW1'(1);
                end
            end
            default:
            begin
                col_x = CW1'(col_reg) + CW1'(1);
            end
        endcase
        if (col_x >= CW1'(COLUMNS))
        begin
            col_x = '0;
            row_x = row_x + RW1'(1);
        end
        put_scroll = (row_x >= RW1'(ROWS));
        if (put_scroll)
        begin
            row_x = RW1'(ROWS - 1);
        end
    end

    // memory ports: the delayed sweep write has the port to itself
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_addr;
        ram_wdata = {attr_reg, char_reg};
        if (pw_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pw_addr_reg;
            ram_wdata = pw_copy_reg ? ram_rdata : fill_reg;
        end
        else if (state_reg == tcc_pkg::ST_EXEC && op_reg == tcc_pkg::OP_PUT && printable)
        begin
            ram_we = 1'b1;
        end
        if (state_reg == tcc_pkg::ST_EXEC)
        begin
            ram_raddr = AW'(idx_reg);
        end
        else
        begin
            ram_raddr = cnt_reg + AW'(COLUMNS);
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        scroll_next   = scroll_reg;
        cnt_next      = cnt_reg;
        fill_next     = fill_reg;
        pw_valid_next = 1'b0;
        pw_addr_next  = cnt_reg;
        pw_copy_next  = 1'b0;
        done_next     = 1'b0;
        cell_out_next = '0;
        case (state_reg)
            tcc_pkg::ST_INIT, tcc_pkg::ST_SWEEP:
            begin
                // scroll copies cell+COLUMNS down; the last row (and clear/init) fills
                pw_valid_next = 1'b1;
                pw_copy_next  = scroll_reg && (32'(cnt_reg) < CELLS - COLUMNS);
                cnt_next      = cnt_reg + AW'(1);
                if (cnt_reg == AW'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == tcc_pkg::ST_INIT) ? tcc_pkg::ST_IDLE
                                                                 : tcc_pkg::ST_DONE;
                end
            end
            tcc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = tcc_pkg::ST_EXEC;
                end
            end
            tcc_pkg::ST_EXEC:
            begin
                scroll_next = 1'b0;
                cnt_next    = '0;
                state_next  = tcc_pkg::ST_DONE;
                case (op_reg)
                    tcc_pkg::OP_PUT:
                    begin
                        row_next    = RW'(row_x);
                        col_next    = CW'(col_x);
                        scroll_next = put_scroll;
                        if (put_scroll)
                        begin
                            fill_next  = '0;
                            state_next = tcc_pkg::ST_SWEEP;
                        end
                    end
                    tcc_pkg::OP_SET:
                    begin
                        row_next = (32'(trow_reg) >= ROWS) ? RW'(ROWS - 1) : RW'(trow_reg);
                        col_next = (32'(tcol_reg) >= COLUMNS) ? CW'(COLUMNS - 1)
                                                              : CW'(tcol_reg);
                    end
                    tcc_pkg::OP_CLEAR:
                    begin
                        row_next   = '0;
                        col_next   = '0;
                        fill_next  = {attr_reg, tcc_pkg::CH_SPACE};
                        state_next = tcc_pkg::ST_SWEEP;
                    end
                    default:
                    begin
                    end
                endcase
            end
            tcc_pkg::ST_DONE:
            begin
                done_next  = 1'b1;
                state_next = tcc_pkg::ST_IDLE;
                if (op_reg == tcc_pkg::OP_READ && !read_oob)
                begin
                    cell_out_next = ram_rdata;
                end
            end
            default:
            begin
                state_next = tcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= tcc_pkg::ST_INIT;
            attr_reg     <= tcc_pkg::ATTR_RESET;
            row_reg      <= '0;
            col_reg      <= '0;
            scroll_reg   <= 1'b0;
            cnt_reg      <= '0;
            fill_reg     <= '0;
            pw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            scroll_reg   <= scroll_next;
            cnt_reg      <= cnt_next;
            fill_reg     <= fill_next;
            pw_valid_reg <= pw_valid_next;
            done_reg     <= done_next;
            if (char_attribute_we)
            begin
                attr_reg <= char_attribute;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pw_addr_reg <= pw_addr_next;
        pw_copy_reg <= pw_copy_next;
        if (accept)
        begin
            op_reg   <= opcode;
            char_reg <= char_code;
            trow_reg <= target_row;
            tcol_reg <= target_col;
            idx_reg  <= cell_index;
        end
        if (state_reg == tcc_pkg::ST_DONE)
        begin
            row_out_reg      <= 5'(row_reg);
            col_out_reg      <= 7'(col_reg);
            pos_out_reg      <= 11'(cur_addr);
            cell_out_reg     <= cell_out_next;
            scrolled_out_reg <= scroll_reg;
        end
    end

    tcc_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign done            = done_reg;
    assign cursor_row_out  = row_out_reg;
    assign cursor_col_out  = col_out_reg;
    assign cursor_position = pos_out_reg;
    assign cell_data       = cell_out_reg;
    assign scrolled        = scrolled_out_reg;

endmodule

### src/tcc_checker.sv
// Port-level checks for the text console cursor engine, bound to the top level.
module tcc_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [4:0]  cursor_row_out,
    input logic [6:0]  cursor_col_out,
    input logic [10:0] cursor_position,
    input logic [15:0] cell_data,
    input logic        scrolled
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("word accepted but engine not busy or stray done");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cursor_position == 11'(32'(cursor_row_out) * COLUMNS + 32'(cursor_col_out)))
        else $error("cursor position does not match row and column");

    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        done && scrolled |-> cursor_row_out == 5'(ROWS - 1) && cell_data == 16'h0000)
        else $error("scroll left cursor off the last row or returned cell data");

endmodule

bind text_console_cursor_engine tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .cursor_row_out  (cursor_row_out),
    .cursor_col_out  (cursor_col_out),
    .cursor_position (cursor_position),
    .cell_data       (cell_data),
    .scrolled        (scrolled)
);

### tb/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text console cursor engine: screen and cursor predictor.
module text_console_cursor_engine_tb;

    localparam int COLUMNS = 80;
    localparam int ROWS = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int PHASE_WORDS = 350;
    localparam int SETTLE_CYCLES = 16;
    // limit above the worst case, in which every word pays a full screen sweep plus the longest gap
    localparam longint LIMIT_CYCLES = 12_000_000;

    typedef struct packed {
        tcc_pkg::op_t opcode;
        logic [7:0]   char_code;
        logic [4:0]   target_row;
        logic [6:0]   target_col;
        logic [10:0]  cell_index;
        logic [3:0]   gap;
    } console_cmd_t;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] pos;
        logic [15:0] data;
        logic        scrolled;
    } cursor_view_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  opcode = tcc_pkg::OP_PUT;
    logic [7:0]  char_code = 8'h00;
    logic [4:0]  target_row = 5'd0;
    logic [6:0]  target_col = 7'd0;
    logic [10:0] cell_index = 11'd0;
    logic        char_attribute_we = 1'b0;
    logic [7:0]  char_attribute = 8'h00;
    logic        done;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic [10:0] cursor_position;
    logic [15:0] cell_data;
    logic        scrolled;

    // predictor state
    logic [15:0]  screen_model [CELL_COUNT];
    int           cur_row;
    int           cur_col;
    logic [7:0]   attr_model;

    console_cmd_t pending_cmds [$];
    cursor_view_t cursor_expect_q [$];
    console_cmd_t cur_cmd;
    int           gap_left = 0;
    bit           gap_taken = 1'b0;
    int           fail_count = 0;
    int           op_hits [4] = '{0, 0, 0, 0};
    int           scroll_hits = 0;
    int           results_seen = 0;
    longint       cycle_count = 0;

    text_console_cursor_engine #(
        .COLUMNS(COLUMNS),
        .ROWS(ROWS)
    ) u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic cursor_view_t console_step(console_cmd_t c);
        cursor_view_t v;
        int i;
        int lin;
        v = '0;
        case (c.opcode)
            tcc_pkg::OP_PUT:
            begin
                case (c.char_code)
                    tcc_pkg::CH_NEWLINE:
                    begin
                        cur_row++;
                        cur_col = 0;
                    end
                    tcc_pkg::CH_RETURN: cur_col = 0;
                    tcc_pkg::CH_TAB:
                        cur_col = (cur_col + tcc_pkg::TAB_STEP) & ~(tcc_pkg::TAB_STEP - 1);
                    tcc_pkg::CH_BACKSPACE: if (cur_col > 0) cur_col--;
                    default:
                    begin
                        screen_model[cur_row * COLUMNS + cur_col] = {attr_model, c.char_code};
                        cur_col++;
                    end
                endcase
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= ROWS)
                begin
                    cur_row = ROWS - 1;
                    for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                        screen_model[i] = screen_model[i + COLUMNS];
                    for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                        screen_model[i] = 16'h0000;
                    v.scrolled = 1'b1;
                end
            end
            tcc_pkg::OP_SET:
            begin
                cur_row = (c.target_row >= ROWS) ? ROWS - 1 : int'(c.target_row);
                cur_col = (c.target_col >= COLUMNS) ? COLUMNS - 1 : int'(c.target_col);
            end
            tcc_pkg::OP_CLEAR:
            begin
                for (i = 0; i < CELL_COUNT; i++)
                    screen_model[i] = {attr_model, tcc_pkg::CH_SPACE};
                cur_row = 0;
                cur_col = 0;
            end
            default:
            begin
                if (c.cell_index < CELL_COUNT)
                    v.data = screen_model[c.cell_index];
            end
        endcase
        lin = cur_row * COLUMNS + cur_col;
        v.row = cur_row[4:0];
        v.col = cur_col[6:0];
        v.pos = lin[10:0];
        return v;
    endfunction

    // driver: start stays up until the word is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                cursor_expect_q.push_back(console_step(cur_cmd));
                op_hits[cur_cmd.opcode]++;
            end
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0 && pending_cmds[0].gap > 0 && !gap_taken)
                begin
                    gap_left = pending_cmds[0].gap - 1;
                    gap_taken = 1'b1;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    gap_taken = 1'b0;
                    opcode <= cur_cmd.opcode;
                    char_code <= cur_cmd.char_code;
                    target_row <= cur_cmd.target_row;
                    target_col <= cur_cmd.target_col;
                    cell_index <= cur_cmd.cell_index;
                    start <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // monitor: one result word per done strobe, no back-pressure
    always @(posedge clk)
    begin
        cursor_view_t want;
        if (rst_n && done === 1'b1)
        begin
            if (cursor_expect_q.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                want = cursor_expect_q.pop_front();
                check_field("cursor_row_out", 16'(want.row), 16'(cursor_row_out));
                check_field("cursor_col_out", 16'(want.col), 16'(cursor_col_out));
                check_field("cursor_position", 16'(want.pos), 16'(cursor_position));
                check_field("cell_data", want.data, cell_data);
                check_field("scrolled", 16'(want.scrolled), 16'(scrolled));
                if (want.scrolled)
                    scroll_hits++;
                results_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic console_cmd_t make_cmd(tcc_pkg::op_t op, int ch, int row, int col,
                                              int idx);
        console_cmd_t c;
        c.opcode = op;
        c.char_code = ch[7:0];
        c.target_row = row[4:0];
        c.target_col = col[6:0];
        c.cell_index = idx[10:0];
        c.gap = '0;
        return c;
    endfunction

    task automatic push_cmd(console_cmd_t c, bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0)
            c.gap = 4'($urandom_range(1, 8));
        pending_cmds.push_back(c);
    endtask

    function automatic int pick_char();
        case ($urandom_range(0, 11))
            0: return tcc_pkg::CH_NEWLINE;
            1: return tcc_pkg::CH_TAB;
            2: return tcc_pkg::CH_BACKSPACE;
            3: return tcc_pkg::CH_RETURN;
            4, 5: return $urandom_range(0, 255);
            default: return $urandom_range(32, 126);
        endcase
    endfunction

    task automatic drain();
        do
            @(posedge clk);
        while (pending_cmds.size() != 0 || start || cursor_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(logic [7:0] value);
        @(posedge clk);
        char_attribute_we <= 1'b1;
        char_attribute <= value;
        attr_model = value;
        @(posedge clk);
        char_attribute_we <= 1'b0;
    endtask

    // bursts: set cursor, a line of text, then reads around it; else a clear or random words
    task automatic fill_random(int words, bit allow_idle);
        int made;
        int kind;
        int n;
        int reads;
        int row;
        int col;
        int base;
        int idx;
        bit quiet;
        made = 0;
        while (made < words)
        begin
            quiet = !allow_idle || ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                row = ($urandom_range(0, 2) == 0) ? ROWS - 1 : $urandom_range(0, 31);
                col = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 127)
                                                  : $urandom_range(0, COLUMNS - 1);
                push_cmd(make_cmd(tcc_pkg::OP_SET, $urandom_range(0, 255), row, col,
                                  $urandom_range(0, 2047)), quiet);
                base = ((row >= ROWS) ? ROWS - 1 : row) * COLUMNS
                     + ((col >= COLUMNS) ? COLUMNS - 1 : col);
                n = $urandom_range(1, 20);
                repeat (n)
                    push_cmd(make_cmd(tcc_pkg::OP_PUT, pick_char(), $urandom_range(0, 31),
                                      $urandom_range(0, 127), $urandom_range(0, 2047)), quiet);
                reads = $urandom_range(1, 4);
                repeat (reads)
                begin
                    // after a scroll the text sits one row higher
                    idx = base + $urandom_range(0, n) - ($urandom_range(0, 1) ? COLUMNS : 0);
                    if (idx < 0)
                        idx = 0;
                    push_cmd(make_cmd(tcc_pkg::OP_READ, $urandom_range(0, 255),
                                      $urandom_range(0, 31), $urandom_range(0, 127), idx),
                             quiet);
                end
                made += 1 + n + reads;
            end
            else if (kind == 6)
            begin
                push_cmd(make_cmd(tcc_pkg::OP_CLEAR, $urandom_range(0, 255),
                                  $urandom_range(0, 31), $urandom_range(0, 127),
                                  $urandom_range(0, 2047)), quiet);
                repeat (2)
                    push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, $urandom_range(0, 2047)),
                             quiet);
                made += 3;
            end
            else
            begin
                n = $urandom_range(1, 6);
                repeat (n)
                    push_cmd(make_cmd(tcc_pkg::op_t'($urandom_range(0, 3)),
                                      $urandom_range(0, 255), $urandom_range(0, 31),
                                      $urandom_range(0, 127), $urandom_range(0, 2047)),
                             quiet);
                made += n;
            end
        end
    endtask

    initial
    begin
        int i;
        for (i = 0; i < CELL_COUNT; i++)
            screen_model[i] = 16'h0000;
        cur_row = 0;
        cur_col = 0;
        attr_model = tcc_pkg::ATTR_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset attribute
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, CELL_COUNT - 1), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 255, 31, 127, 2047), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, 8'h41, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, 8'hFF, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, 8'h00, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_TAB, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_BACKSPACE, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_RETURN, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_BACKSPACE, 0, 0, 0), 1'b0);
        // saturating set, then wrap off the last cell scrolls
        push_cmd(make_cmd(tcc_pkg::OP_SET, 0, 31, 127, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, 8'h5A, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, CELL_COUNT - COLUMNS - 1), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, CELL_COUNT - 1), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_SET, 0, ROWS - 1, COLUMNS - 2, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_TAB, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_NEWLINE, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_SET, 0, 3, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, tcc_pkg::CH_NEWLINE, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_CLEAR, 0, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, 100), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_SET, 0, 0, COLUMNS - 1, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_PUT, 8'h78, 0, 0, 0), 1'b0);
        push_cmd(make_cmd(tcc_pkg::OP_READ, 0, 0, 0, COLUMNS - 1), 1'b0);
        drain();

        write_attribute(8'hFF);
        fill_random(PHASE_WORDS, 1'b1);
        drain();
        write_attribute(8'h00);
        fill_random(PHASE_WORDS, 1'b1);
        drain();
        write_attribute(8'($urandom_range(1, 254)));
        fill_random(PHASE_WORDS, 1'b1);
        drain();
        // closing phase runs back to back
        write_attribute(8'($urandom_range(0, 255)));
        fill_random(PHASE_WORDS, 1'b0);
        drain();

        $display("checked %0d result words: %0d put, %0d set, %0d clear, %0d read",
                 results_seen, op_hits[tcc_pkg::OP_PUT], op_hits[tcc_pkg::OP_SET],
                 op_hits[tcc_pkg::OP_CLEAR], op_hits[tcc_pkg::OP_READ]);
        $display("%0d scrolls seen, attribute register at 0x0C, 0xFF, 0x00 and two random values",
                 scroll_hits);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
